FILE: rtl/ttb_pkg.sv
package ttb_pkg;

   // Component range of the incoming fields; narrower settings clamp on entry.
   localparam int COMPONENT_BITS = 16;

   localparam int IN_W    = 16;                  // input field width
   localparam int Q14_W   = 16;                  // Q2.14 output component
   localparam int PROD_W  = 2 * IN_W;            // 16x16 product
   localparam int RAW_W   = PROD_W + 1;          // difference of two products
   localparam int MAG_W   = RAW_W - 1;           // magnitude of a raw component
   localparam int SUM_W   = 2 * MAG_W;           // sum of squares
   localparam int ROOT_W  = SUM_W / 2;           // integer square root
   localparam int FRAC_SHIFT = 15;               // numerator scale: 2 * 16384
   localparam int DIVD_W  = ROOT_W + FRAC_SHIFT + 1;
   localparam int DIVS_W  = ROOT_W + 1;
   localparam int QUO_W   = 15;                  // quotient never exceeds 16384
   localparam int LIMIT_W = 24;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd17;
   localparam int ONE_Q14 = 16384;

   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = QUO_W;
   localparam int PRE_STAGES = 5;
   localparam int NORM_LAT   = PRE_STAGES + SQRT_STEPS + 1 + DIV_STEPS + 1;
   localparam int BT_LAT     = 5;
   localparam int FRONT_LAT  = 3;
   localparam int TOTAL_LAT  = FRONT_LAT + NORM_LAT + BT_LAT;

   localparam int OUT_DATA_W = 9 * Q14_W;
   localparam int OUT_USER_W = 2;

   typedef logic signed [RAW_W-1:0] raw_type;
   typedef logic signed [Q14_W-1:0] q14_type;

   // Clamp one input component to the signed COMPONENT_BITS range.
   function automatic logic signed [IN_W-1:0] sat_comp(input logic signed [IN_W-1:0] v);
      longint lim;
      longint x;
      lim = longint'(1) <<< (COMPONENT_BITS - 1);
      x = longint'(v);
      if (x > lim - 1) x = lim - 1;
      if (x < -lim) x = -lim;
      return x[IN_W-1:0];
   endfunction

endpackage

FILE: rtl/ttb_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module ttb_isqrt (
   input  logic                        clock,
   input  logic                        en,
   input  logic [ttb_pkg::SUM_W-1:0]   radicand,
   output logic [ttb_pkg::ROOT_W-1:0]  root
);

   logic [ttb_pkg::SUM_W-1:0] x_ff   [ttb_pkg::SQRT_STEPS];
   logic [ttb_pkg::SUM_W-1:0] res_ff [ttb_pkg::SQRT_STEPS];
   logic [ttb_pkg::SUM_W-1:0] x_in   [ttb_pkg::SQRT_STEPS];
   logic [ttb_pkg::SUM_W-1:0] res_in [ttb_pkg::SQRT_STEPS];

   always_comb begin
      logic [ttb_pkg::SUM_W-1:0] xs;
      logic [ttb_pkg::SUM_W-1:0] rs;
      logic [ttb_pkg::SUM_W-1:0] bitv;
      logic [ttb_pkg::SUM_W-1:0] t;
      for (int k = 0; k < ttb_pkg::SQRT_STEPS; k++) begin
         if (k == 0) begin
            xs = radicand;
            rs = '0;
         end else begin
            xs = x_ff[k-1];
            rs = res_ff[k-1];
         end
         bitv = {{(ttb_pkg::SUM_W-1){1'b0}}, 1'b1} << (ttb_pkg::SUM_W - 2 - 2 * k);
         t = rs + bitv;
         if (xs >= t) begin
            x_in[k]   = xs - t;
            res_in[k] = (rs >> 1) + bitv;
         end else begin
            x_in[k]   = xs;
            res_in[k] = rs >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < ttb_pkg::SQRT_STEPS; k++) begin
            x_ff[k]   <= x_in[k];
            res_ff[k] <= res_in[k];
         end
      end
   end

   assign root = res_ff[ttb_pkg::SQRT_STEPS-1][ttb_pkg::ROOT_W-1:0];

endmodule

FILE: rtl/ttb_qdiv.sv
// Pipelined restoring divider, one quotient bit per stage.
module ttb_qdiv (
   input  logic                        clock,
   input  logic                        en,
   input  logic [ttb_pkg::DIVD_W-1:0]  dividend,
   input  logic [ttb_pkg::DIVS_W-1:0]  divisor,
   output logic [ttb_pkg::QUO_W-1:0]   quotient
);

   logic [ttb_pkg::DIVD_W-1:0] rem_ff [ttb_pkg::DIV_STEPS];
   logic [ttb_pkg::DIVS_W-1:0] dvs_ff [ttb_pkg::DIV_STEPS];
   logic [ttb_pkg::QUO_W-1:0]  quo_ff [ttb_pkg::DIV_STEPS];
   logic [ttb_pkg::DIVD_W-1:0] rem_in [ttb_pkg::DIV_STEPS];
   logic [ttb_pkg::QUO_W-1:0]  quo_in [ttb_pkg::DIV_STEPS];

   always_comb begin
      logic [ttb_pkg::DIVD_W-1:0] rs;
      logic [ttb_pkg::DIVS_W-1:0] ds;
      logic [ttb_pkg::QUO_W-1:0]  qs;
      logic [ttb_pkg::DIVD_W-1:0] dsh;
      for (int k = 0; k < ttb_pkg::DIV_STEPS; k++) begin
         if (k == 0) begin
            rs = dividend;
            ds = divisor;
            qs = '0;
         end else begin
            rs = rem_ff[k-1];
            ds = dvs_ff[k-1];
            qs = quo_ff[k-1];
         end
         dsh = {{(ttb_pkg::DIVD_W-ttb_pkg::DIVS_W){1'b0}}, ds} << (ttb_pkg::QUO_W - 1 - k);
         if (rs >= dsh) begin
            rem_in[k] = rs - dsh;
            quo_in[k] = {qs[ttb_pkg::QUO_W-2:0], 1'b1};
         end else begin
            rem_in[k] = rs;
            quo_in[k] = {qs[ttb_pkg::QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < ttb_pkg::DIV_STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            dvs_ff[k] <= (k == 0) ? divisor : dvs_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   assign quotient = quo_ff[ttb_pkg::DIV_STEPS-1];

endmodule

FILE: rtl/ttb_vec_norm.sv
// Normalize a 3-vector to Q2.14: squares, sum, even pre-shift, square root,
// then one divide per component.
module ttb_vec_norm (
   input  logic              clock,
   input  logic              en,
   input  ttb_pkg::raw_type  vec_in [3],
   output ttb_pkg::q14_type  unit_out [3]
);

   typedef struct packed {
      logic [2:0][ttb_pkg::MAG_W-1:0] mag;
      logic [2:0]                     neg;
      logic                           zero;
   } side_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
   } sign_type;

   logic [ttb_pkg::MAG_W-1:0] mag1_ff [3];
   logic [2:0]                neg1_ff;
   logic [ttb_pkg::SUM_W-1:0] sq2_ff [3];
   side_type                  side2_ff;
   logic [ttb_pkg::SUM_W-1:0] sum3_ff;
   side_type                  side3_ff;
   logic [ttb_pkg::SUM_W-1:0] s4_ff;
   side_type                  side4_ff;
   logic [ttb_pkg::SUM_W-1:0] s5_ff;
   side_type                  side5_ff;
   side_type                  sq_dly_ff [ttb_pkg::SQRT_STEPS];
   logic [ttb_pkg::DIVD_W-1:0] dvd_ff [3];
   logic [ttb_pkg::DIVS_W-1:0] dvs_ff;
   sign_type                  sign_d0_ff;
   sign_type                  dv_dly_ff [ttb_pkg::DIV_STEPS];
   ttb_pkg::q14_type          unit_ff [3];

   logic [ttb_pkg::MAG_W-1:0] mag1_in [3];
   logic [ttb_pkg::SUM_W-1:0] s4_in;
   side_type                  side4_in;
   logic [ttb_pkg::SUM_W-1:0] s5_in;
   side_type                  side5_in;
   logic [ttb_pkg::ROOT_W-1:0] root;
   logic [ttb_pkg::QUO_W-1:0] quo [3];
   ttb_pkg::q14_type          unit_in [3];

   always_comb begin
      ttb_pkg::raw_type absv;
      for (int i = 0; i < 3; i++) begin
         absv = (vec_in[i] < 0) ? -vec_in[i] : vec_in[i];
         mag1_in[i] = absv[ttb_pkg::MAG_W-1:0];
      end
   end

   // Coarse pre-shift: 32, 16, 8 bits on the sum, half that on magnitudes.
   always_comb begin
      s4_in = sum3_ff;
      side4_in = side3_ff;
      for (int j = 0; j < 3; j++) begin
         if ((s4_in >> (ttb_pkg::SUM_W - (32 >> j))) == '0) begin
            s4_in = s4_in << (32 >> j);
            for (int i = 0; i < 3; i++) side4_in.mag[i] = side4_in.mag[i] << (16 >> j);
         end
      end
   end

   // Fine pre-shift: 4, 2 bits; leaves one of the top two bits set.
   always_comb begin
      s5_in = s4_ff;
      side5_in = side4_ff;
      for (int j = 0; j < 2; j++) begin
         if ((s5_in >> (ttb_pkg::SUM_W - (4 >> j))) == '0) begin
            s5_in = s5_in << (4 >> j);
            for (int i = 0; i < 3; i++) side5_in.mag[i] = side5_in.mag[i] << (2 >> j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mag1_ff[i] <= mag1_in[i];
            neg1_ff[i] <= vec_in[i] < 0;
            sq2_ff[i]  <= mag1_ff[i] * mag1_ff[i];
            side2_ff.mag[i] <= mag1_ff[i];
         end
         side2_ff.neg  <= neg1_ff;
         side2_ff.zero <= (mag1_ff[0] == '0) && (mag1_ff[1] == '0) && (mag1_ff[2] == '0);
         sum3_ff  <= sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
         side3_ff <= side2_ff;
         s4_ff    <= s4_in;
         side4_ff <= side4_in;
         s5_ff    <= s5_in;
         side5_ff <= side5_in;
         sq_dly_ff[0] <= side5_ff;
         for (int k = 1; k < ttb_pkg::SQRT_STEPS; k++) sq_dly_ff[k] <= sq_dly_ff[k-1];
      end
   end

   ttb_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .radicand (s5_ff),
      .root     (root)
   );

   // Rounded quotient: (m * 2^15 + r) / (2 r).
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dvd_ff[i] <= ({{(ttb_pkg::DIVD_W-ttb_pkg::MAG_W){1'b0}},
                           sq_dly_ff[ttb_pkg::SQRT_STEPS-1].mag[i]} << ttb_pkg::FRAC_SHIFT)
                         + {{(ttb_pkg::DIVD_W-ttb_pkg::ROOT_W){1'b0}}, root};
         end
         dvs_ff <= {root, 1'b0};
         sign_d0_ff.neg  <= sq_dly_ff[ttb_pkg::SQRT_STEPS-1].neg;
         sign_d0_ff.zero <= sq_dly_ff[ttb_pkg::SQRT_STEPS-1].zero;
         dv_dly_ff[0] <= sign_d0_ff;
         for (int k = 1; k < ttb_pkg::DIV_STEPS; k++) dv_dly_ff[k] <= dv_dly_ff[k-1];
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_div
      ttb_qdiv u_qdiv (
         .clock    (clock),
         .en       (en),
         .dividend (dvd_ff[i]),
         .divisor  (dvs_ff),
         .quotient (quo[i])
      );
   end

   always_comb begin
      logic [ttb_pkg::QUO_W-1:0] qs;
      ttb_pkg::q14_type          qv;
      for (int i = 0; i < 3; i++) begin
         qs = (quo[i] > ttb_pkg::QUO_W'(ttb_pkg::ONE_Q14)) ?
              ttb_pkg::QUO_W'(ttb_pkg::ONE_Q14) : quo[i];
         qv = {{(ttb_pkg::Q14_W-ttb_pkg::QUO_W){1'b0}}, qs};
         if (dv_dly_ff[ttb_pkg::DIV_STEPS-1].zero) unit_in[i] = '0;
         else if (dv_dly_ff[ttb_pkg::DIV_STEPS-1].neg[i]) unit_in[i] = -qv;
         else unit_in[i] = qv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) unit_ff[i] <= unit_in[i];
      end
   end

   assign unit_out = unit_ff;

endmodule

FILE: rtl/ttb_bitan.sv
// Bitangent: normal x tangent rounded to Q2.14, flipped against the binormal.
module ttb_bitan (
   input  logic              clock,
   input  logic              en,
   input  ttb_pkg::q14_type  nrm [3],
   input  ttb_pkg::q14_type  tan [3],
   input  ttb_pkg::q14_type  bin [3],
   output ttb_pkg::q14_type  bt [3]
);

   logic signed [ttb_pkg::PROD_W-1:0] p1_ff [6];
   logic signed [ttb_pkg::RAW_W-1:0]  c2_ff [3];
   ttb_pkg::q14_type                  bt3_ff [3];
   logic signed [ttb_pkg::PROD_W-1:0] d4_ff [3];
   ttb_pkg::q14_type                  bt4_ff [3];
   ttb_pkg::q14_type                  bt5_ff [3];
   ttb_pkg::q14_type                  bin1_ff [3];
   ttb_pkg::q14_type                  bin2_ff [3];
   ttb_pkg::q14_type                  bin3_ff [3];
   ttb_pkg::q14_type                  bt3_in [3];
   ttb_pkg::q14_type                  bt5_in [3];

   // Round Q4.28 to Q2.14, ties away from zero, clamp to one.
   always_comb begin
      logic [ttb_pkg::RAW_W-1:0] mag;
      logic [ttb_pkg::RAW_W-1:0] q;
      ttb_pkg::q14_type          qv;
      for (int i = 0; i < 3; i++) begin
         mag = (c2_ff[i] < 0) ? -c2_ff[i] : c2_ff[i];
         q = (mag + ttb_pkg::RAW_W'(8192)) >> 14;
         if (q > ttb_pkg::RAW_W'(ttb_pkg::ONE_Q14)) q = ttb_pkg::RAW_W'(ttb_pkg::ONE_Q14);
         qv = q[ttb_pkg::Q14_W-1:0];
         bt3_in[i] = (c2_ff[i] < 0) ? -qv : qv;
      end
   end

   always_comb begin
      logic signed [ttb_pkg::PROD_W+1:0] dot;
      dot = {{2{d4_ff[0][ttb_pkg::PROD_W-1]}}, d4_ff[0]}
          + {{2{d4_ff[1][ttb_pkg::PROD_W-1]}}, d4_ff[1]}
          + {{2{d4_ff[2][ttb_pkg::PROD_W-1]}}, d4_ff[2]};
      for (int i = 0; i < 3; i++) bt5_in[i] = (dot < 0) ? -bt4_ff[i] : bt4_ff[i];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff[0] <= nrm[1] * tan[2];
         p1_ff[1] <= nrm[2] * tan[1];
         p1_ff[2] <= nrm[2] * tan[0];
         p1_ff[3] <= nrm[0] * tan[2];
         p1_ff[4] <= nrm[0] * tan[1];
         p1_ff[5] <= nrm[1] * tan[0];
         for (int i = 0; i < 3; i++) begin
            bin1_ff[i] <= bin[i];
            bin2_ff[i] <= bin1_ff[i];
            bin3_ff[i] <= bin2_ff[i];
            c2_ff[i]   <= {p1_ff[2*i][ttb_pkg::PROD_W-1], p1_ff[2*i]}
                        - {p1_ff[2*i+1][ttb_pkg::PROD_W-1], p1_ff[2*i+1]};
            bt3_ff[i]  <= bt3_in[i];
            d4_ff[i]   <= bt3_ff[i] * bin3_ff[i];
            bt4_ff[i]  <= bt3_ff[i];
            bt5_ff[i]  <= bt5_in[i];
         end
      end
   end

   assign bt = bt5_ff;

endmodule

FILE: rtl/triangle_tangent_basis.sv
// Per-triangle tangent frame. Each req transaction carries one triangle (two
// Q8.8 edge vectors and two Q4.12 UV deltas); each rsp transaction returns the
// unit normal, unit tangent and sign-corrected bitangent in Q2.14 plus the
// uv_degenerate and zero_area flags. One triangle is taken every clock unless
// the output buffer holds the pipeline; each passes through the 32-stage square
// root and the 15-stage divider in each of the three vector normalizers.
// A two-entry output buffer keeps the pipeline moving while a result waits;
// the pipeline holds only once both entries are full. csr_we writes the
// degenerate limit (Q8.24, reset 17); write it only while the block is idle.
module triangle_tangent_basis (
   input  logic                               clock,
   input  logic                               reset,
   // edge_a_x, edge_a_y, edge_a_z, edge_b_x, edge_b_y, edge_b_z, du_a, dv_a,
   // du_b, dv_b (16 bits each, lowest first)
   input  logic [10*ttb_pkg::IN_W-1:0]        req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // normal_x/y/z, tangent_x/y/z, bitangent_x/y/z (16 bits each, lowest first)
   output logic [ttb_pkg::OUT_DATA_W-1:0]     rsp_tdata,
   // uv_degenerate, zero_area (lowest first)
   output logic [ttb_pkg::OUT_USER_W-1:0]     rsp_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_we,
   input  logic [ttb_pkg::LIMIT_W-1:0]        csr_wdata
);

   typedef struct packed {
      logic uv_degenerate;
      logic zero_area;
   } flag_type;

   typedef struct packed {
      logic [2:0][ttb_pkg::Q14_W-1:0] normal;
      logic [2:0][ttb_pkg::Q14_W-1:0] tangent;
      flag_type                       flags;
   } side_type;

   typedef struct packed {
      logic [ttb_pkg::OUT_DATA_W-1:0] data;
      logic [ttb_pkg::OUT_USER_W-1:0] user;
   } result_type;

   // Control
   logic                           en;
   logic [ttb_pkg::TOTAL_LAT-1:0]  valid_ff;
   logic                           deliver;
   logic                           out_free;
   logic                           out_valid_ff, out_valid_in;
   logic                           spare_valid_ff, spare_valid_in;
   logic [ttb_pkg::LIMIT_W-1:0]    limit_ff;

   // Input fields after clamping
   logic signed [ttb_pkg::IN_W-1:0] ea [3];
   logic signed [ttb_pkg::IN_W-1:0] eb [3];
   logic signed [ttb_pkg::IN_W-1:0] du_a, dv_a, du_b, dv_b;

   // Front end: products, differences, sign fix-up
   logic signed [ttb_pkg::PROD_W-1:0] pc_ff [6];
   logic signed [ttb_pkg::PROD_W-1:0] pt_ff [6];
   logic signed [ttb_pkg::PROD_W-1:0] pb_ff [6];
   logic signed [ttb_pkg::PROD_W-1:0] pd_ff [2];
   ttb_pkg::raw_type                  cr2_ff [3];
   ttb_pkg::raw_type                  tr2_ff [3];
   ttb_pkg::raw_type                  br2_ff [3];
   ttb_pkg::raw_type                  det2_ff;
   ttb_pkg::raw_type                  cr3_ff [3];
   ttb_pkg::raw_type                  tr3_ff [3];
   ttb_pkg::raw_type                  br3_ff [3];
   flag_type                          flag3_ff;
   flag_type                          flag3_in;

   // Normalizers and alignment
   ttb_pkg::q14_type nrm [3];
   ttb_pkg::q14_type tan_n [3];
   ttb_pkg::q14_type bin_n [3];
   ttb_pkg::q14_type tan_sel [3];
   ttb_pkg::q14_type bin_sel [3];
   ttb_pkg::q14_type bt [3];
   flag_type         flag_dly_ff [ttb_pkg::NORM_LAT];
   side_type         side_dly_ff [ttb_pkg::BT_LAT];
   side_type         side_in;

   // Output buffer
   result_type result;
   result_type out_ff, out_in;
   result_type spare_ff, spare_in;

   // Hold the whole pipeline only when the spare entry is occupied.
   assign en         = !spare_valid_ff;
   assign req_tready = en;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ea[i] = ttb_pkg::sat_comp(req_tdata[ttb_pkg::IN_W*i +: ttb_pkg::IN_W]);
         eb[i] = ttb_pkg::sat_comp(req_tdata[ttb_pkg::IN_W*(3+i) +: ttb_pkg::IN_W]);
      end
      du_a = ttb_pkg::sat_comp(req_tdata[ttb_pkg::IN_W*6 +: ttb_pkg::IN_W]);
      dv_a = ttb_pkg::sat_comp(req_tdata[ttb_pkg::IN_W*7 +: ttb_pkg::IN_W]);
      du_b = ttb_pkg::sat_comp(req_tdata[ttb_pkg::IN_W*8 +: ttb_pkg::IN_W]);
      dv_b = ttb_pkg::sat_comp(req_tdata[ttb_pkg::IN_W*9 +: ttb_pkg::IN_W]);
   end

   // Stage 1: all 16x16 products for the cross product, the two UV-weighted
   // edge combinations and the UV determinant.
   always_ff @(posedge clock) begin
      if (en) begin
         pc_ff[0] <= ea[1] * eb[2];
         pc_ff[1] <= ea[2] * eb[1];
         pc_ff[2] <= ea[2] * eb[0];
         pc_ff[3] <= ea[0] * eb[2];
         pc_ff[4] <= ea[0] * eb[1];
         pc_ff[5] <= ea[1] * eb[0];
         for (int i = 0; i < 3; i++) begin
            pt_ff[i]   <= ea[i] * dv_b;
            pt_ff[3+i] <= eb[i] * dv_a;
            pb_ff[i]   <= eb[i] * du_a;
            pb_ff[3+i] <= ea[i] * du_b;
         end
         pd_ff[0] <= du_a * dv_b;
         pd_ff[1] <= dv_a * du_b;
      end
   end

   // Stage 2: differences, exact in 33 bits.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            cr2_ff[i] <= {pc_ff[2*i][ttb_pkg::PROD_W-1], pc_ff[2*i]}
                       - {pc_ff[2*i+1][ttb_pkg::PROD_W-1], pc_ff[2*i+1]};
            tr2_ff[i] <= {pt_ff[i][ttb_pkg::PROD_W-1], pt_ff[i]}
                       - {pt_ff[3+i][ttb_pkg::PROD_W-1], pt_ff[3+i]};
            br2_ff[i] <= {pb_ff[i][ttb_pkg::PROD_W-1], pb_ff[i]}
                       - {pb_ff[3+i][ttb_pkg::PROD_W-1], pb_ff[3+i]};
         end
         det2_ff <= {pd_ff[0][ttb_pkg::PROD_W-1], pd_ff[0]}
                  - {pd_ff[1][ttb_pkg::PROD_W-1], pd_ff[1]};
      end
   end

   // Stage 3: the reciprocal determinant reduces to its sign, since both
   // vectors get normalized. A zero determinant counts as positive.
   always_comb begin
      logic [ttb_pkg::RAW_W-1:0] mag_det;
      mag_det = (det2_ff < 0) ? -det2_ff : det2_ff;
      flag3_in.uv_degenerate =
         mag_det < {{(ttb_pkg::RAW_W-ttb_pkg::LIMIT_W){1'b0}}, limit_ff};
      flag3_in.zero_area = (cr2_ff[0] == '0) && (cr2_ff[1] == '0) && (cr2_ff[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            cr3_ff[i] <= cr2_ff[i];
            tr3_ff[i] <= (det2_ff < 0) ? -tr2_ff[i] : tr2_ff[i];
            br3_ff[i] <= (det2_ff < 0) ? -br2_ff[i] : br2_ff[i];
         end
         flag3_ff <= flag3_in;
         flag_dly_ff[0] <= flag3_ff;
         for (int k = 1; k < ttb_pkg::NORM_LAT; k++) flag_dly_ff[k] <= flag_dly_ff[k-1];
      end
   end

   ttb_vec_norm u_norm_n (.clock(clock), .en(en), .vec_in(cr3_ff), .unit_out(nrm));
   ttb_vec_norm u_norm_t (.clock(clock), .en(en), .vec_in(tr3_ff), .unit_out(tan_n));
   ttb_vec_norm u_norm_b (.clock(clock), .en(en), .vec_in(br3_ff), .unit_out(bin_n));

   // Substitute the fixed frame for a degenerate UV mapping.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tan_sel[i] = tan_n[i];
         bin_sel[i] = bin_n[i];
      end
      if (flag_dly_ff[ttb_pkg::NORM_LAT-1].uv_degenerate) begin
         tan_sel[0] = ttb_pkg::Q14_W'(ttb_pkg::ONE_Q14);
         tan_sel[1] = '0;
         tan_sel[2] = '0;
         bin_sel[0] = '0;
         bin_sel[1] = '0;
         bin_sel[2] = ttb_pkg::Q14_W'(ttb_pkg::ONE_Q14);
      end
      for (int i = 0; i < 3; i++) begin
         side_in.normal[i]  = nrm[i];
         side_in.tangent[i] = tan_sel[i];
      end
      side_in.flags = flag_dly_ff[ttb_pkg::NORM_LAT-1];
   end

   ttb_bitan u_bitan (
      .clock (clock),
      .en    (en),
      .nrm   (nrm),
      .tan   (tan_sel),
      .bin   (bin_sel),
      .bt    (bt)
   );

   // Carry normal, tangent and flags alongside the bitangent stages.
   always_ff @(posedge clock) begin
      if (en) begin
         side_dly_ff[0] <= side_in;
         for (int k = 1; k < ttb_pkg::BT_LAT; k++) side_dly_ff[k] <= side_dly_ff[k-1];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         result.data[ttb_pkg::Q14_W*i +: ttb_pkg::Q14_W] =
            side_dly_ff[ttb_pkg::BT_LAT-1].normal[i];
         result.data[ttb_pkg::Q14_W*(3+i) +: ttb_pkg::Q14_W] =
            side_dly_ff[ttb_pkg::BT_LAT-1].tangent[i];
         result.data[ttb_pkg::Q14_W*(6+i) +: ttb_pkg::Q14_W] = bt[i];
      end
      result.user = {side_dly_ff[ttb_pkg::BT_LAT-1].flags.zero_area,
                     side_dly_ff[ttb_pkg::BT_LAT-1].flags.uv_degenerate};
   end

   // Output buffer: the pipeline drops a finished transaction into the output
   // register, or into the spare entry when the output is still waiting.
   assign deliver  = en && valid_ff[ttb_pkg::TOTAL_LAT-1];
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_in         = out_ff;
      spare_in       = spare_ff;
      out_valid_in   = out_valid_ff;
      spare_valid_in = spare_valid_ff;
      if (spare_valid_ff) begin
         if (out_free) begin
            out_in         = spare_ff;
            out_valid_in   = 1'b1;
            spare_valid_in = 1'b0;
         end
      end else if (deliver) begin
         if (out_free) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            spare_in       = result;
            spare_valid_in = 1'b1;
         end
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
         limit_ff       <= ttb_pkg::LIMIT_RESET;
      end else begin
         if (en) valid_ff <= {valid_ff[ttb_pkg::TOTAL_LAT-2:0], req_tvalid};
         out_valid_ff   <= out_valid_in;
         spare_valid_ff <= spare_valid_in;
         if (csr_we) limit_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      out_ff   <= out_in;
      spare_ff <= spare_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.data;
   assign rsp_tuser  = out_ff.user;

endmodule

FILE: tb/sv/tb_triangle_tangent_basis.sv
`timescale 1ns / 100ps

// Scoreboard for the tangent-frame block: holds the limit register copy and
// the queue of expected frames, computes each frame from the triangle.
class frame_scoreboard;
   typedef struct packed {
      logic [15:0] nx, ny, nz, tx, ty, tz, bx, by, bz;
      logic        uv_degen, zero_area;
   } frame_type;

   frame_type   pending_frames[$];
   logic [23:0] limit;
   int          mismatches;
   int          degen_seen, zero_seen;

   function new();
      limit = ttb_pkg::LIMIT_RESET;
      mismatches = 0;
      degen_seen = 0;
      zero_seen = 0;
   endfunction

   static function longint isqrt(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return longint'(res);
   endfunction

   static function void make_unit(input longint v[3], output longint o[3]);
      longint unsigned m[3], s, r, num, q;
      int sh;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = (v[i] < 0) ? -v[i] : v[i];
         s += m[i] * m[i];
      end
      if (s == 0) begin
         o[0] = 0; o[1] = 0; o[2] = 0;
         return;
      end
      sh = 0;
      while ((s >> (62 - sh)) == 0) sh += 2;
      r = isqrt(s << sh);
      for (int i = 0; i < 3; i++) begin
         num = m[i] << (sh / 2);
         q = ((num << 15) + r) / (2 * r);
         if (q > 16384) q = 16384;
         o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
   endfunction

   static function longint round_q14(longint x);
      longint unsigned mag, q;
      mag = (x < 0) ? -x : x;
      q = (mag + 8192) >> 14;
      if (q > 16384) q = 16384;
      return (x < 0) ? -longint'(q) : longint'(q);
   endfunction

   static function void cross3(input longint a[3], input longint b[3], output longint c[3]);
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   // Note an accepted triangle and queue its expected frame.
   function void note_triangle(logic [159:0] tri_bits);
      longint ea[3], eb[3], cr[3], nrm[3], tng[3], bin[3], raw[3], bt[3];
      longint dua, dva, dub, dvb, det, dot, sg;
      longint unsigned mag;
      frame_type f;
      for (int i = 0; i < 3; i++) begin
         ea[i] = longint'($signed(tri_bits[16*i +: 16]));
         eb[i] = longint'($signed(tri_bits[16*(3+i) +: 16]));
      end
      dua = longint'($signed(tri_bits[96 +: 16]));
      dva = longint'($signed(tri_bits[112 +: 16]));
      dub = longint'($signed(tri_bits[128 +: 16]));
      dvb = longint'($signed(tri_bits[144 +: 16]));
      cross3(ea, eb, cr);
      f.zero_area = (cr[0] == 0 && cr[1] == 0 && cr[2] == 0);
      make_unit(cr, nrm);
      det = dua * dvb - dva * dub;
      mag = (det < 0) ? -det : det;
      f.uv_degen = mag < limit;
      if (f.uv_degen) begin
         tng[0] = 16384; tng[1] = 0; tng[2] = 0;
         bin[0] = 0; bin[1] = 0; bin[2] = 16384;
      end else begin
         sg = (det < 0) ? -1 : 1;
         for (int i = 0; i < 3; i++) raw[i] = sg * (ea[i] * dvb - eb[i] * dva);
         make_unit(raw, tng);
         for (int i = 0; i < 3; i++) raw[i] = sg * (eb[i] * dua - ea[i] * dub);
         make_unit(raw, bin);
      end
      cross3(nrm, tng, raw);
      for (int i = 0; i < 3; i++) bt[i] = round_q14(raw[i]);
      dot = bt[0] * bin[0] + bt[1] * bin[1] + bt[2] * bin[2];
      // flip bitangent to agree with the UV-derived binormal
      if (dot < 0) for (int i = 0; i < 3; i++) bt[i] = -bt[i];
      f.nx = 16'(nrm[0]); f.ny = 16'(nrm[1]); f.nz = 16'(nrm[2]);
      f.tx = 16'(tng[0]); f.ty = 16'(tng[1]); f.tz = 16'(tng[2]);
      f.bx = 16'(bt[0]); f.by = 16'(bt[1]); f.bz = 16'(bt[2]);
      if (f.uv_degen) degen_seen++;
      if (f.zero_area) zero_seen++;
      pending_frames.insert(pending_frames.size(), f);
   endfunction

   function void cmp(string name, logic [15:0] e, logic [15:0] a);
      if (e !== a) begin
         $error("%s: expected %0d, actual %0d", name, $signed(e), $signed(a));
         mismatches++;
      end
   endfunction

   // Check one returned frame against the oldest expectation.
   function void check_frame(logic [143:0] d, logic [1:0] u);
      frame_type f;
      if (pending_frames.size() == 0) begin
         $error("unexpected result transaction: tdata %h tuser %b", d, u);
         mismatches++;
         return;
      end
      f = pending_frames.pop_front();
      cmp("normal_x", f.nx, d[0 +: 16]);
      cmp("normal_y", f.ny, d[16 +: 16]);
      cmp("normal_z", f.nz, d[32 +: 16]);
      cmp("tangent_x", f.tx, d[48 +: 16]);
      cmp("tangent_y", f.ty, d[64 +: 16]);
      cmp("tangent_z", f.tz, d[80 +: 16]);
      cmp("bitangent_x", f.bx, d[96 +: 16]);
      cmp("bitangent_y", f.by, d[112 +: 16]);
      cmp("bitangent_z", f.bz, d[128 +: 16]);
      cmp("uv_degenerate", 16'(f.uv_degen), 16'(u[0]));
      cmp("zero_area", 16'(f.zero_area), 16'(u[1]));
   endfunction
endclass

module tb_triangle_tangent_basis;

   localparam int WATCHDOG_LIMIT = 20000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic [159:0]                   req_tdata = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ttb_pkg::OUT_DATA_W-1:0] rsp_tdata;
   logic [ttb_pkg::OUT_USER_W-1:0] rsp_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic                           csr_we = 1'b0;
   logic [ttb_pkg::LIMIT_W-1:0]    csr_wdata = '0;

   frame_scoreboard frames = new();
   int  send_idle_pct = 0;   // chance per cycle that the sender holds off
   int  recv_stall_pct = 0;  // chance per cycle that the receiver stalls
   int  idle_cycles = 0;
   int  sent_count = 0;
   int  recv_count = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   triangle_tangent_basis u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // Receiver: randomize tready each cycle, check every accepted result.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         frames.check_frame(rsp_tdata[143:0], rsp_tuser);
         recv_count++;
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: count cycles without any transaction on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Send one triangle; hold valid until accepted, insert random idle first.
   task automatic send_triangle(logic [159:0] tri_bits);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= tri_bits;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      frames.note_triangle(tri_bits);
      sent_count++;
   endtask

   task automatic finish_sending();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Drain all expectations, then let the pipeline settle before a write.
   task automatic drain();
      finish_sending();
      while (frames.pending_frames.size() != 0) @(posedge clock);
      repeat (ttb_pkg::TOTAL_LAT + 8) @(posedge clock);
   endtask

   task automatic write_limit(logic [ttb_pkg::LIMIT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      frames.limit = value;
   endtask

   function automatic logic [15:0] rand_comp(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(64)) - 32);
         2: return ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
         default: return 16'($signed($urandom_range(4096)) - 2048);
      endcase
   endfunction

   // Random triangle; some share an edge direction (zero area) or tie UVs.
   function automatic logic [159:0] rand_triangle();
      logic [159:0] t;
      int mode;
      int shape;
      mode  = $urandom_range(3);
      shape = $urandom_range(9);
      for (int i = 0; i < 10; i++) t[16*i +: 16] = rand_comp($urandom_range(1) ? mode : 0);
      if (shape == 0) begin
         // edge_b parallel to edge_a
         t[48 +: 48] = t[0 +: 48];
      end else if (shape == 1) begin
         // du_b, dv_b equal to du_a, dv_a: zero determinant
         t[128 +: 32] = t[96 +: 32];
      end else if (shape == 2) begin
         for (int i = 6; i < 10; i++) t[16*i +: 16] = 16'($signed($urandom_range(6)) - 3);
      end
      return t;
   endfunction

   task automatic random_phase(int count, int idle_pct, int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_triangle(rand_triangle());
      drain();
   endtask

   function automatic logic [159:0] pack_tri(logic [15:0] ax, ay, az, bx, by, bz,
                                             ua, va, ub, vb);
      return {vb, ub, va, ua, bz, by, bx, az, ay, ax};
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed triangles at the reset limit.
      send_triangle(pack_tri(16'h0100, 16'd0, 16'd0, 16'd0, 16'h0100, 16'd0,
                             16'h1000, 16'd0, 16'd0, 16'h1000));
      send_triangle(pack_tri(16'h0100, 16'd0, 16'd0, 16'd0, 16'h0100, 16'd0,
                             16'd0, 16'h1000, 16'h1000, 16'd0));
      send_triangle(pack_tri(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                             16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
      send_triangle(pack_tri(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                             16'h8000, 16'h8000, 16'h8000, 16'h8000));
      send_triangle('0);                                                // zero everything
      send_triangle(pack_tri(16'd1, 16'd2, 16'd3, 16'd2, 16'd4, 16'd6,
                             16'h1000, 16'd0, 16'd0, 16'h1000));       // zero area
      send_triangle(pack_tri(16'h0100, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0100,
                             16'd4, 16'd0, 16'd0, 16'd4));             // |D| = 16 < 17
      send_triangle(pack_tri(16'h0100, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0100,
                             16'd17, 16'd0, 16'd0, 16'd1));            // |D| = 17
      send_triangle(pack_tri(16'd0, 16'h0100, 16'd0, 16'h0100, 16'd0, 16'd0,
                             16'hFFFF, 16'd0, 16'd0, 16'hFFFF));
      send_triangle(pack_tri(16'h0300, 16'hFE00, 16'h0050, 16'hFF00, 16'h0200, 16'h0400,
                             16'hF000, 16'h0800, 16'h0400, 16'hF800));
      send_triangle(pack_tri(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'hFFFE,
                             16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000));
      drain();

      // Limit zero: a zero determinant is then not degenerate.
      write_limit(24'd0);
      send_triangle(pack_tri(16'h0100, 16'd0, 16'd0, 16'd0, 16'h0100, 16'd0,
                             16'd1, 16'd1, 16'd1, 16'd1));
      send_triangle(pack_tri(16'h0100, 16'd0, 16'd0, 16'd0, 16'h0100, 16'd0,
                             16'h1000, 16'd0, 16'd0, 16'h1000));
      random_phase(90, 0, 0);

      // Largest limit: almost everything takes the fixed frame.
      write_limit(24'hFFFFFF);
      send_triangle(pack_tri(16'h0100, 16'd0, 16'd0, 16'd0, 16'h0100, 16'd0,
                             16'h7FFF, 16'd0, 16'd0, 16'h7FFF));
      random_phase(90, 53, 0);

      write_limit(24'h000400);
      random_phase(90, 0, 53);

      write_limit(24'(17));
      random_phase(90, 30, 30);

      write_limit(24'($urandom));
      random_phase(90, 0, 0);

      write_limit(24'($urandom_range(1 << 16)));
      random_phase(90, 53, 53);

      $display("covered %0d triangles, %0d results; %0d with fixed UV frame, %0d zero area",
               sent_count, recv_count, frames.degen_seen, frames.zero_seen);
      $display("limit settings from 0 to full scale, with and without idling on both sides");
      if (frames.mismatches == 0 && frames.pending_frames.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
